// ===== sv/bbn_pkg.sv =====
package bbn_pkg;

  // Coordinate width default and fixed field widths
  localparam int COORD_WIDTH_DEF = 32;
  localparam int IN_W            = 32;
  localparam int OUT_W           = 18;
  localparam int QUOT_W          = 18;
  localparam int NUM_AXES        = 3;
  localparam int AXIS_W          = 2;
  localparam int PC_W            = 4;
  localparam int CNT_W           = $clog2(QUOT_W);

  localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(NUM_AXES - 1);
  localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(QUOT_W - 1);

  // Saturation limits of signed Q1.16
  localparam logic [QUOT_W-1:0] OUT_MAX_POS = 18'd131071;
  localparam logic [QUOT_W-1:0] OUT_MIN_MAG = 18'd131072;

  // Function selector codes
  localparam logic [1:0] FUNC_CLEAR   = 2'd0;
  localparam logic [1:0] FUNC_MEASURE = 2'd1;
  localparam logic [1:0] FUNC_NORM    = 2'd2;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_EXT,
    OP_MAX,
    OP_CHKDEG,
    OP_CENTRE,
    OP_DIFF,
    OP_MAG,
    OP_SAT,
    OP_DIV,
    OP_STORE,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_DEGEN,
    C_CNT_NZ,
    C_MORE_AXES,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
    logic            load_cnt;
  } uword_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    op_e               op;
    logic [AXIS_W-1:0] axis;
  } ctrl_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic start;
    logic degen;
    logic out_busy;
  } stat_t;

  // Per-transfer commands to the bounds registers
  typedef struct packed {
    logic clear;
    logic measure;
  } bnd_cmd_t;

  // Program addresses
  localparam logic [PC_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] ST_EXT    = 4'd1;
  localparam logic [PC_W-1:0] ST_MAX    = 4'd2;
  localparam logic [PC_W-1:0] ST_CHKDEG = 4'd3;
  localparam logic [PC_W-1:0] ST_AXIS   = 4'd4;
  localparam logic [PC_W-1:0] ST_DIFF   = 4'd5;
  localparam logic [PC_W-1:0] ST_MAG    = 4'd6;
  localparam logic [PC_W-1:0] ST_SAT    = 4'd7;
  localparam logic [PC_W-1:0] ST_DIV    = 4'd8;
  localparam logic [PC_W-1:0] ST_STORE  = 4'd9;
  localparam logic [PC_W-1:0] ST_EMIT   = 4'd10;
  localparam logic [PC_W-1:0] ST_WRAP   = 4'd11;

  // Microcode program: untaken jump falls through to the next step
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: ST_IDLE, load_cnt: 1'b0};
    unique case (pc)
      ST_IDLE:   w = '{op: OP_ACCEPT, cond: C_NO_START,  target: ST_IDLE,  load_cnt: 1'b0};
      ST_EXT:    w = '{op: OP_EXT,    cond: C_NEVER,     target: ST_IDLE,  load_cnt: 1'b0};
      ST_MAX:    w = '{op: OP_MAX,    cond: C_NEVER,     target: ST_IDLE,  load_cnt: 1'b0};
      ST_CHKDEG: w = '{op: OP_CHKDEG, cond: C_DEGEN,     target: ST_EMIT,  load_cnt: 1'b0};
      ST_AXIS:   w = '{op: OP_CENTRE, cond: C_NEVER,     target: ST_IDLE,  load_cnt: 1'b0};
      ST_DIFF:   w = '{op: OP_DIFF,   cond: C_NEVER,     target: ST_IDLE,  load_cnt: 1'b0};
      ST_MAG:    w = '{op: OP_MAG,    cond: C_NEVER,     target: ST_IDLE,  load_cnt: 1'b1};
      ST_SAT:    w = '{op: OP_SAT,    cond: C_NEVER,     target: ST_IDLE,  load_cnt: 1'b0};
      ST_DIV:    w = '{op: OP_DIV,    cond: C_CNT_NZ,    target: ST_DIV,   load_cnt: 1'b0};
      ST_STORE:  w = '{op: OP_STORE,  cond: C_MORE_AXES, target: ST_AXIS,  load_cnt: 1'b0};
      ST_EMIT:   w = '{op: OP_EMIT,   cond: C_OUT_BUSY,  target: ST_EMIT,  load_cnt: 1'b0};
      ST_WRAP:   w = '{op: OP_NOP,    cond: C_ALWAYS,    target: ST_IDLE,  load_cnt: 1'b0};
      default:   w = '{op: OP_NOP,    cond: C_ALWAYS,    target: ST_IDLE,  load_cnt: 1'b0};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/bbn_seq.sv =====
module bbn_seq
  import bbn_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  logic [PC_W-1:0]   pc_q, pc_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [AXIS_W-1:0] axis_q, axis_d;
  uword_t            uw;
  logic              take;

  assign uw = ucode_rom(pc_q);

  // Jump condition
  always_comb begin
    unique case (uw.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_START:  take = !stat_i.start;
      C_DEGEN:     take = stat_i.degen;
      C_CNT_NZ:    take = (cnt_q != '0);
      C_MORE_AXES: take = (axis_q != AXIS_LAST);
      C_OUT_BUSY:  take = stat_i.out_busy;
      default:     take = 1'b0;
    endcase
  end

  // Step counter, loop counter, axis counter
  always_comb begin
    pc_d   = take ? uw.target : pc_q + PC_W'(1);
    cnt_d  = cnt_q;
    axis_d = axis_q;
    if (uw.load_cnt) begin
      cnt_d = DIV_LAST;
    end else if (uw.op == OP_DIV) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
    if (uw.op == OP_CHKDEG) begin
      axis_d = '0;
    end else if (uw.op == OP_STORE) begin
      axis_d = axis_q + AXIS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= ST_IDLE;
      cnt_q  <= '0;
      axis_q <= '0;
    end else begin
      pc_q   <= pc_d;
      cnt_q  <= cnt_d;
      axis_q <= axis_d;
    end
  end

  assign ctrl_o = '{op: uw.op, axis: axis_q};

endmodule

// ===== sv/bbn_bounds.sv =====
module bbn_bounds
  import bbn_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bnd_cmd_t                cmd_i,
  input  ctrl_t                   ctrl_i,
  input  logic signed [COORD_WIDTH-1:0] coord_i [NUM_AXES],
  output logic signed [COORD_WIDTH-1:0] low_sel_o,
  output logic signed [COORD_WIDTH:0]   ext_sel_o,
  output logic signed [COORD_WIDTH:0]   ext_max_o
);

  localparam int CW = COORD_WIDTH;
  localparam int EW = COORD_WIDTH + 1;
  localparam logic signed [CW-1:0] MOST_POS = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MOST_NEG = {1'b1, {(CW-1){1'b0}}};

  logic signed [CW-1:0] low_q  [NUM_AXES];
  logic signed [CW-1:0] high_q [NUM_AXES];
  logic signed [EW-1:0] ext_q  [NUM_AXES];
  logic signed [EW-1:0] max_q, max_d;

  // Running per-axis bounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        low_q[a]  <= MOST_POS;
        high_q[a] <= MOST_NEG;
      end
    end else if (cmd_i.clear) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        low_q[a]  <= MOST_POS;
        high_q[a] <= MOST_NEG;
      end
    end else if (cmd_i.measure) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (coord_i[a] < low_q[a])  low_q[a]  <= coord_i[a];
        if (coord_i[a] > high_q[a]) high_q[a] <= coord_i[a];
      end
    end
  end

  // Largest extent of the three axes
  always_comb begin
    max_d = ext_q[0];
    if (ext_q[1] > max_d) max_d = ext_q[1];
    if (ext_q[2] > max_d) max_d = ext_q[2];
  end

  // Extents at the extent step and their maximum at the max step
  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_EXT) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        ext_q[a] <= EW'(high_q[a]) - EW'(low_q[a]);
      end
    end
    if (ctrl_i.op == OP_MAX) begin
      max_q <= max_d;
    end
  end

  assign low_sel_o = low_q[ctrl_i.axis];
  assign ext_sel_o = ext_q[ctrl_i.axis];
  assign ext_max_o = max_q;

endmodule

// ===== sv/bbn_div.sv =====
module bbn_div
  import bbn_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  ctrl_t                         ctrl_i,
  input  logic signed [COORD_WIDTH:0]   diff_i,
  input  logic signed [COORD_WIDTH:0]   divisor_i,
  output logic        [OUT_W-1:0]       result_o
);

  localparam int EW = COORD_WIDTH + 1;
  localparam int RW = COORD_WIDTH + 2;

  logic [RW-1:0]     rem_q;
  logic [QUOT_W-1:0] quot_q;
  logic              neg_q;
  logic              sat_q;

  logic [RW-1:0]     div_u, div2_u, rem_sub, rem_keep;
  logic [EW-1:0]     mag;
  logic              ge;
  logic [QUOT_W-1:0] q_lim;

  // Divisor is positive whenever the divider runs
  assign div_u  = {1'b0, divisor_i};
  assign div2_u = {divisor_i, 1'b0};
  assign mag    = diff_i[EW-1] ? EW'(-diff_i) : EW'(diff_i);

  // One restoring step: trial subtract, keep, shift
  assign ge       = (rem_q >= div_u);
  assign rem_sub  = rem_q - div_u;
  assign rem_keep = ge ? rem_sub : rem_q;

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      OP_MAG: begin
        neg_q <= diff_i[EW-1];
        rem_q <= {1'b0, mag};
      end
      OP_SAT: begin
        sat_q  <= (rem_q >= div2_u);
        quot_q <= '0;
      end
      OP_DIV: begin
        rem_q  <= {rem_keep[RW-2:0], 1'b0};
        quot_q <= {quot_q[QUOT_W-2:0], ge};
      end
      default: begin
      end
    endcase
  end

  // Saturate to Q1.16 and apply the sign
  always_comb begin
    if (neg_q) begin
      q_lim    = (sat_q || (quot_q > OUT_MIN_MAG)) ? OUT_MIN_MAG : quot_q;
      result_o = OUT_W'(-q_lim);
    end else begin
      q_lim    = (sat_q || (quot_q > OUT_MAX_POS)) ? OUT_MAX_POS : quot_q;
      result_o = OUT_W'(q_lim);
    end
  end

endmodule

// ===== sv/bounding_box_unit_normalizer_unit.sv =====
// Bounding-box unit-cube normalizer.
// Input channel (in_valid_i / in_stall_o) carries func_i and a Q16.16 vertex.
// func 0 clears the running bounds and func 1 folds the vertex into them;
// both finish in the transfer cycle and give no result. func 3 is ignored.
// func 2 normalizes the vertex against the bounds and gives one result on the
// output channel (out_valid_o / out_stall_i): three Q1.16 values, saturated,
// and a degenerate flag that forces them to zero when the largest extent is
// not positive.
// A normalize that is degenerate skips the per-axis work and goes straight
// to emit; otherwise the shared restoring divider runs one step per quotient
// bit for each axis under the microcode sequencer. The input is stalled
// meanwhile and until a wrap step after the emit.
// Clear and measure items are taken one per cycle while no normalize runs.
// Reset sets every low bound to the most positive and every high bound to
// the most negative coordinate and empties the output register.
// A stalled result holds; the sequencer waits at the emit step until the
// output register is free, while earlier results are not disturbed.
module bounding_box_unit_normalizer_unit
  import bbn_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              func_i,
  input  logic signed [IN_W-1:0]  x_coord_i,
  input  logic signed [IN_W-1:0]  y_coord_i,
  input  logic signed [IN_W-1:0]  z_coord_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] norm_x_o,
  output logic signed [OUT_W-1:0] norm_y_o,
  output logic signed [OUT_W-1:0] norm_z_o,
  output logic                    degenerate_o
);

  localparam int CW = COORD_WIDTH;
  localparam int EW = COORD_WIDTH + 1;

  ctrl_t    ctrl;
  stat_t    stat;
  bnd_cmd_t bcmd;
  logic     in_xfer;
  logic     out_busy;

  logic [CW+IN_W-1:0]   x_wide, y_wide, z_wide;
  logic signed [CW-1:0] coord [NUM_AXES];
  logic signed [CW-1:0] vtx_q [NUM_AXES];

  logic signed [CW-1:0] low_sel;
  logic signed [EW-1:0] ext_sel, ext_max;
  logic signed [EW-1:0] centre_q, diff_q;
  logic [OUT_W-1:0]     div_res;
  logic [OUT_W-1:0]     norm_q [NUM_AXES];
  logic                 degen_q;
  logic                 out_valid_q, out_valid_d;
  logic [OUT_W-1:0]     out_x_q, out_y_q, out_z_q;
  logic                 out_deg_q;

  // Take the low COORD_WIDTH bits of each field as a signed coordinate
  assign x_wide   = {{CW{1'b0}}, x_coord_i};
  assign y_wide   = {{CW{1'b0}}, y_coord_i};
  assign z_wide   = {{CW{1'b0}}, z_coord_i};
  assign coord[0] = x_wide[CW-1:0];
  assign coord[1] = y_wide[CW-1:0];
  assign coord[2] = z_wide[CW-1:0];

  // Input handshake
  assign in_stall_o = (ctrl.op != OP_ACCEPT);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign bcmd       = '{clear:   in_xfer && (func_i == FUNC_CLEAR),
                        measure: in_xfer && (func_i == FUNC_MEASURE)};

  assign out_busy = out_valid_q && out_stall_i;
  assign stat     = '{start:    in_valid_i && (func_i == FUNC_NORM),
                      degen:    (ext_max <= EW'(0)),
                      out_busy: out_busy};

  bbn_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  bbn_bounds #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_bounds (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (bcmd),
    .ctrl_i    (ctrl),
    .coord_i   (coord),
    .low_sel_o (low_sel),
    .ext_sel_o (ext_sel),
    .ext_max_o (ext_max)
  );

  bbn_div #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_div (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .diff_i    (diff_q),
    .divisor_i (ext_max),
    .result_o  (div_res)
  );

  // Vertex capture, centre, difference and per-axis results
  always_ff @(posedge clk_i) begin
    if (in_xfer && (func_i == FUNC_NORM)) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        vtx_q[a] <= coord[a];
      end
    end
    unique case (ctrl.op)
      OP_CHKDEG: degen_q <= stat.degen;
      OP_CENTRE: begin
        if (ext_sel < 0) begin
          centre_q <= EW'(low_sel);
        end else begin
          centre_q <= EW'(low_sel) + (ext_sel >>> 1);
        end
      end
      OP_DIFF:   diff_q <= EW'(vtx_q[ctrl.axis]) - centre_q;
      OP_STORE:  norm_q[ctrl.axis] <= div_res;
      default: begin
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if ((ctrl.op == OP_EMIT) && !out_busy) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((ctrl.op == OP_EMIT) && !out_busy) begin
      out_x_q   <= degen_q ? '0 : norm_q[0];
      out_y_q   <= degen_q ? '0 : norm_q[1];
      out_z_q   <= degen_q ? '0 : norm_q[2];
      out_deg_q <= degen_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign norm_x_o     = out_x_q;
  assign norm_y_o     = out_y_q;
  assign norm_z_o     = out_z_q;
  assign degenerate_o = out_deg_q;

  // A degenerate result carries zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> (norm_x_o == '0) && (norm_y_o == '0) && (norm_z_o == '0))
    else $error("degenerate result with nonzero coordinates");

  // A normalize transfer blocks the input on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (func_i == FUNC_NORM) |=> in_stall_o)
    else $error("input not stalled after normalize transfer");

  // A new result appears only from the emit step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(ctrl.op == OP_EMIT))
    else $error("result raised outside the emit step");

endmodule
